// ----- rtl/aip_pkg.sv -----
// Shared types and constants of the ASCII integer parser.
// Holds the classified character item and the parse phase encoding.
// No dependencies.
`default_nettype none

package aip_pkg;

	localparam logic [1:0] BASE_AUTO = 2'd0;
	localparam logic [1:0] BASE_DEC  = 2'd1;
	localparam logic [1:0] BASE_HEX  = 2'd2;
	localparam logic [1:0] BASE_RESERVED = 2'd3;

	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_HT    = 8'h09;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;
	localparam logic [7:0] CHR_LC_X  = 8'h78;
	localparam logic [7:0] CHR_UC_X  = 8'h58;
	localparam logic [7:0] CHR_LC_A  = 8'h61;
	localparam logic [7:0] CHR_LC_F  = 8'h66;
	localparam logic [7:0] CHR_UC_A  = 8'h41;
	localparam logic [7:0] CHR_UC_F  = 8'h46;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;
	localparam logic [3:0] LETTER_OFFSET = 4'd9;

	typedef struct packed {
		logic       last;
		logic       is_space;
		logic       is_sign;
		logic       is_neg;
		logic       is_zero;
		logic       is_x;
		logic       dec_ok;
		logic       hex_ok;
		logic [3:0] digit;
	} item_t;

	typedef enum logic [6:0] {
		PH_SPACE  = 7'b0000001,
		PH_START  = 7'b0000010,
		PH_ZERO   = 7'b0000100,
		PH_PREFIX = 7'b0001000,
		PH_DEC    = 7'b0010000,
		PH_HEX    = 7'b0100000,
		PH_DONE   = 7'b1000000
	} phase_t;

endpackage

`default_nettype wire

// ----- rtl/aip_front.sv -----
// Front end of the ASCII integer parser: accepts characters and classifies them.
// Depends on aip_pkg for the classified item type and character constants.
`default_nettype none

module aip_front (
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_char,
	input  wire logic          in_last,
	input  wire logic          q_full,
	output logic               q_push,
	output aip_pkg::item_t     q_item
);

	logic is_letter_lc;
	logic is_letter_uc;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	assign is_letter_lc = (in_char >= aip_pkg::CHR_LC_A) && (in_char <= aip_pkg::CHR_LC_F);
	assign is_letter_uc = (in_char >= aip_pkg::CHR_UC_A) && (in_char <= aip_pkg::CHR_UC_F);

	always_comb begin
		q_item.last     = in_last;
		q_item.is_space = (in_char == aip_pkg::CHR_SPACE) ||
		                  ((in_char >= aip_pkg::CHR_HT) && (in_char <= aip_pkg::CHR_CR));
		q_item.is_sign  = (in_char == aip_pkg::CHR_PLUS) || (in_char == aip_pkg::CHR_MINUS);
		q_item.is_neg   = (in_char == aip_pkg::CHR_MINUS);
		q_item.is_zero  = (in_char == aip_pkg::CHR_ZERO);
		q_item.is_x     = (in_char == aip_pkg::CHR_LC_X) || (in_char == aip_pkg::CHR_UC_X);
		q_item.dec_ok   = (in_char >= aip_pkg::CHR_ZERO) && (in_char <= aip_pkg::CHR_NINE);
		q_item.hex_ok   = q_item.dec_ok || is_letter_lc || is_letter_uc;
		if (q_item.dec_ok) begin
			q_item.digit = in_char[3:0] & aip_pkg::NIBBLE_MASK;
		end else begin
			q_item.digit = in_char[3:0] + aip_pkg::LETTER_OFFSET;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/aip_queue.sv -----
// Two-entry queue of classified items between the front and back ends.
// Depends on aip_pkg for the item type.
`default_nettype none

module aip_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire aip_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output aip_pkg::item_t      head_item
);

	aip_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- rtl/aip_back.sv -----
// Back end of the ASCII integer parser: parse phase, accumulator and result register.
// Depends on aip_pkg for the item type, phase encoding and base codes.
`default_nettype none

module aip_back #(
	parameter int VALUE_BITS = 32,
	parameter int POS_BITS   = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_base,
	input  wire logic                  q_valid,
	input  wire aip_pkg::item_t        q_item,
	output logic                       q_pop,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output logic [VALUE_BITS-1:0]      res_value,
	output logic [POS_BITS-1:0]        res_end_position,
	output logic                       res_converted,
	output logic                       res_overflow
);

	localparam int SUM_W = VALUE_BITS + 5;

	logic [1:0]            base_q;
	aip_pkg::phase_t       phase_q;
	logic                  neg_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic [POS_BITS-1:0]   pos_q;
	logic [POS_BITS-1:0]   cons_q;
	logic                  ovf_q;
	logic                  any_q;

	aip_pkg::phase_t       ph;
	logic                  neg_n;
	logic                  sign_taken;
	logic                  do_acc;
	logic                  acc_hex;
	logic [3:0]            acc_d;
	logic                  mode_dec;
	logic                  mode_hex;
	logic                  hex_cur;
	logic [POS_BITS-1:0]   pos_next;
	logic [SUM_W-1:0]      mag_ext;
	logic [SUM_W-1:0]      prod;
	logic [SUM_W-1:0]      sum;
	logic [SUM_W-1:0]      lim;
	logic                  acc_ovf;
	logic [VALUE_BITS-1:0] mag_n;
	logic [POS_BITS-1:0]   cons_n;
	logic                  ovf_n;
	logic                  any_n;
	logic [VALUE_BITS-1:0] value_n;

	assign q_pop    = q_valid && (!res_valid || res_ready);
	assign mode_dec = (base_q == aip_pkg::BASE_DEC);
	assign mode_hex = (base_q == aip_pkg::BASE_HEX);
	assign pos_next = (&pos_q) ? pos_q : pos_q + 1'b1;

	always_comb begin
		ph         = phase_q;
		neg_n      = neg_q;
		sign_taken = 1'b0;
		do_acc     = 1'b0;
		acc_hex    = 1'b0;
		acc_d      = q_item.digit;
		hex_cur    = (phase_q != aip_pkg::PH_DEC);

		if (phase_q == aip_pkg::PH_SPACE && !q_item.is_space) begin
			ph = aip_pkg::PH_START;
			if (q_item.is_sign) begin
				neg_n      = q_item.is_neg;
				sign_taken = 1'b1;
			end
		end

		if (ph == aip_pkg::PH_START && !sign_taken) begin
			if (q_item.is_zero) begin
				do_acc = 1'b1;
				acc_d  = 4'd0;
				ph     = mode_dec ? aip_pkg::PH_DEC : aip_pkg::PH_ZERO;
			end else if (mode_hex ? q_item.hex_ok : q_item.dec_ok) begin
				do_acc  = 1'b1;
				acc_hex = mode_hex;
				ph      = mode_hex ? aip_pkg::PH_HEX : aip_pkg::PH_DEC;
			end else begin
				ph = aip_pkg::PH_DONE;
			end
		end else if (phase_q == aip_pkg::PH_ZERO) begin
			if (q_item.is_x) begin
				ph = aip_pkg::PH_PREFIX;
			end else if (mode_hex ? q_item.hex_ok : q_item.dec_ok) begin
				do_acc  = 1'b1;
				acc_hex = mode_hex;
				ph      = mode_hex ? aip_pkg::PH_HEX : aip_pkg::PH_DEC;
			end else begin
				ph = aip_pkg::PH_DONE;
			end
		end else if (phase_q == aip_pkg::PH_PREFIX || phase_q == aip_pkg::PH_HEX ||
		             phase_q == aip_pkg::PH_DEC) begin
			if (hex_cur ? q_item.hex_ok : q_item.dec_ok) begin
				do_acc  = 1'b1;
				acc_hex = hex_cur;
				ph      = hex_cur ? aip_pkg::PH_HEX : aip_pkg::PH_DEC;
			end else begin
				ph = aip_pkg::PH_DONE;
			end
		end
	end

	// A digit that would take acc*base+digit beyond the signed limit saturates at that limit and sets overflow.
	always_comb begin
		mag_ext = SUM_W'(mag_q);
		if (acc_hex) begin
			prod = mag_ext << 4;
		end else begin
			prod = (mag_ext << 3) + (mag_ext << 1);
		end
		sum     = prod + SUM_W'(acc_d);
		lim     = (SUM_W'(1) << (VALUE_BITS - 1)) - SUM_W'(1) + SUM_W'(neg_n);
		acc_ovf = ovf_q || (sum > lim);

		mag_n  = mag_q;
		cons_n = cons_q;
		ovf_n  = ovf_q;
		any_n  = any_q;
		if (do_acc) begin
			mag_n  = acc_ovf ? lim[VALUE_BITS-1:0] : sum[VALUE_BITS-1:0];
			ovf_n  = acc_ovf;
			cons_n = pos_next;
			any_n  = 1'b1;
		end

		if (!any_n) begin
			value_n = '0;
		end else if (neg_n) begin
			value_n = -mag_n;
		end else begin
			value_n = mag_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= aip_pkg::BASE_AUTO;
			phase_q   <= aip_pkg::PH_SPACE;
			neg_q     <= 1'b0;
			mag_q     <= '0;
			pos_q     <= '0;
			cons_q    <= '0;
			ovf_q     <= 1'b0;
			any_q     <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_base;
			end
			if (res_ready) begin
				res_valid <= 1'b0;
			end
			if (q_pop) begin
				if (q_item.last) begin
					phase_q   <= aip_pkg::PH_SPACE;
					neg_q     <= 1'b0;
					mag_q     <= '0;
					pos_q     <= '0;
					cons_q    <= '0;
					ovf_q     <= 1'b0;
					any_q     <= 1'b0;
					res_valid <= 1'b1;
				end else begin
					phase_q <= ph;
					neg_q   <= neg_n;
					mag_q   <= mag_n;
					pos_q   <= pos_next;
					cons_q  <= cons_n;
					ovf_q   <= ovf_n;
					any_q   <= any_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.last) begin
			res_value        <= value_n;
			res_end_position <= any_n ? cons_n : '0;
			res_converted    <= any_n;
			res_overflow     <= ovf_n;
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_item.last |=> phase_q == aip_pkg::PH_SPACE && !any_q && !ovf_q)
		else $error("parse state not cleared after the last item");

	a_ovf_implies_conv: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !res_overflow || res_converted)
		else $error("overflow reported without a conversion");

	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(mag_q) <= (SUM_W'(1) << (VALUE_BITS - 1)))
		else $error("magnitude beyond the signed limit");

endmodule

`default_nettype wire

// ----- rtl/ascii_integer_parser.sv -----
// ASCII integer parser: turns a stream of characters, one per item with tlast on the final
// one, into a signed integer in decimal or hexadecimal, with saturation on overflow. It takes
// one character every clock cycle unless a held result stalls it; the back end's shift-and-add
// accumulate sets that rate. A result is registered once its last character leaves the queue.
`default_nettype none

module ascii_integer_parser #(
	parameter int VALUE_BITS = 32,
	parameter int POS_BITS   = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_data,      // base_select
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,  // character
	input  wire logic                  s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// value, end_position, converted, overflow, then zero padding
	output logic [((VALUE_BITS + POS_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

	localparam int OUT_W = ((VALUE_BITS + POS_BITS + 2 + 7) / 8) * 8;

	aip_pkg::item_t        push_item;
	aip_pkg::item_t        head_item;
	logic                  q_full;
	logic                  q_push;
	logic                  q_pop;
	logic                  head_valid;
	logic [VALUE_BITS-1:0] res_value;
	logic [POS_BITS-1:0]   res_end_position;
	logic                  res_converted;
	logic                  res_overflow;

	assign cfg_ready = 1'b1;

	aip_front u_front (
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_char  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	aip_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	aip_back #(
		.VALUE_BITS (VALUE_BITS),
		.POS_BITS   (POS_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_base         (cfg_data),
		.q_valid          (head_valid),
		.q_item           (head_item),
		.q_pop            (q_pop),
		.res_valid        (m_axis_tvalid),
		.res_ready        (m_axis_tready),
		.res_value        (res_value),
		.res_end_position (res_end_position),
		.res_converted    (res_converted),
		.res_overflow     (res_overflow)
	);

	assign m_axis_tdata = OUT_W'({res_overflow, res_converted, res_end_position, res_value});

endmodule

`default_nettype wire

// ----- tb/ascii_integer_parser_checker.sv -----
`timescale 1ns / 100ps
// Checker for the ASCII integer parser: follows the configuration, character and result channels,
// predicts each parsed number and compares it with what the block returns.
// Depends on aip_pkg for the base codes, character constants and phase encoding.

module ascii_integer_parser_checker
	import aip_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [55:0] m_axis_tdata,
	output int          mismatches,
	output int          results_owed
);

	typedef struct {
		logic [31:0] value;
		logic [15:0] end_position;
		logic        converted;
		logic        overflow;
	} parsed_number_t;

	parsed_number_t expected_numbers[$];

	logic [1:0]  base_sel;
	phase_t      phase;
	logic        negative;
	logic [31:0] magnitude;
	logic [15:0] char_pos;
	logic [15:0] consumed;
	logic        overflowed;
	logic        any_digit;

	initial begin
		mismatches = 0;
		results_owed = 0;
	end

	function automatic bit is_blank(input logic [7:0] c);
		return c == CHR_SPACE || (c >= CHR_HT && c <= CHR_CR);
	endfunction

	function automatic int digit_value(input logic [7:0] c, input bit hex);
		if (c >= CHR_ZERO && c <= CHR_NINE)
			return int'(c - CHR_ZERO);
		if (!hex)
			return -1;
		if (c >= CHR_LC_A && c <= CHR_LC_F)
			return int'(c - CHR_LC_A) + 10;
		if (c >= CHR_UC_A && c <= CHR_UC_F)
			return int'(c - CHR_UC_A) + 10;
		return -1;
	endfunction

	task automatic clear_parse();
		phase = PH_SPACE;
		negative = 1'b0;
		magnitude = '0;
		char_pos = '0;
		consumed = '0;
		overflowed = 1'b0;
		any_digit = 1'b0;
	endtask

	// Saturates at the largest magnitude the sign allows; later digits are still consumed.
	task automatic add_digit(input int d, input bit hex, input logic [15:0] pos_next);
		longint unsigned lim;
		longint unsigned radix;
		lim = 64'h7FFF_FFFF + (negative ? 64'd1 : 64'd0);
		radix = hex ? 64'd16 : 64'd10;
		if (overflowed || longint'(magnitude) > (lim - longint'(d)) / radix) begin
			overflowed = 1'b1;
			magnitude = lim[31:0];
		end else begin
			magnitude = 32'(longint'(magnitude) * radix + longint'(d));
		end
		any_digit = 1'b1;
		consumed = pos_next;
	endtask

	task automatic first_digit(input logic [7:0] c, input bit mode_hex,
			input logic [15:0] pos_next);
		int d;
		d = digit_value(c, mode_hex);
		if (d >= 0) begin
			add_digit(d, mode_hex, pos_next);
			phase = mode_hex ? PH_HEX : PH_DEC;
		end else begin
			phase = PH_DONE;
		end
	endtask

	task automatic parse_character(input logic [7:0] c, input logic lst);
		logic [15:0]    pos_next;
		bit             mode_dec;
		bit             mode_hex;
		bit             sign_taken;
		bit             hex;
		int             d;
		parsed_number_t num;
		pos_next = (char_pos != 16'hFFFF) ? char_pos + 16'd1 : char_pos;
		mode_dec = (base_sel == BASE_DEC);
		mode_hex = (base_sel == BASE_HEX);
		sign_taken = 1'b0;
		if (phase == PH_SPACE && !is_blank(c)) begin
			phase = PH_START;
			if (c == CHR_PLUS || c == CHR_MINUS) begin
				negative = (c == CHR_MINUS);
				sign_taken = 1'b1;
			end
		end
		if (phase == PH_START && !sign_taken) begin
			if (c == CHR_ZERO) begin
				add_digit(0, 1'b0, pos_next);
				phase = mode_dec ? PH_DEC : PH_ZERO;
			end else begin
				first_digit(c, mode_hex, pos_next);
			end
		end else if (phase == PH_ZERO) begin
			if (c == CHR_LC_X || c == CHR_UC_X)
				phase = PH_PREFIX;
			else
				first_digit(c, mode_hex, pos_next);
		end else if (phase == PH_PREFIX || phase == PH_HEX || phase == PH_DEC) begin
			hex = (phase != PH_DEC);
			d = digit_value(c, hex);
			if (d >= 0) begin
				add_digit(d, hex, pos_next);
				phase = hex ? PH_HEX : PH_DEC;
			end else begin
				phase = PH_DONE;
			end
		end
		char_pos = pos_next;
		if (lst) begin
			num.value = any_digit ? (negative ? 32'd0 - magnitude : magnitude) : 32'd0;
			num.end_position = any_digit ? consumed : 16'd0;
			num.converted = any_digit;
			num.overflow = overflowed;
			expected_numbers.push_back(num);
			clear_parse();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_number(input logic [55:0] word);
		parsed_number_t want;
		if (expected_numbers.size() == 0) begin
			report_mismatch("unexpected result", 64'(word), 64'd0);
		end else begin
			want = expected_numbers.pop_front();
			if (word[31:0] !== want.value)
				report_mismatch("value", 64'(word[31:0]), 64'(want.value));
			if (word[47:32] !== want.end_position)
				report_mismatch("end_position", 64'(word[47:32]), 64'(want.end_position));
			if (word[48] !== want.converted)
				report_mismatch("converted", 64'(word[48]), 64'(want.converted));
			if (word[49] !== want.overflow)
				report_mismatch("overflow", 64'(word[49]), 64'(want.overflow));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_sel = BASE_AUTO;
			clear_parse();
			expected_numbers.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				base_sel = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				parse_character(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				check_number(m_axis_tdata);
		end
		results_owed = expected_numbers.size();
	end

endmodule

// ----- tb/ascii_integer_parser_tb.sv -----
`timescale 1ns / 100ps
// Top of the ASCII integer parser testbench: clock, reset, character stimulus and the verdict.
// Depends on aip_pkg, the ascii_integer_parser block and ascii_integer_parser_checker.

module ascii_integer_parser_tb;
	import aip_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int CHARS_PER_PHASE = 180;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	int          mismatches;
	int          results_owed;
	int          quiet_cycles;
	bit          steady;
	logic [7:0]  text[$];

	ascii_integer_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	ascii_integer_parser_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.results_owed  (results_owed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int hold;
		m_axis_tready = 1'b0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else begin
				m_axis_tready <= 1'b1;
				hold = pick_gap();
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the item was taken.
	task automatic send_char(input logic [7:0] c, input logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= lst;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_text();
		for (int i = 0; i < text.size(); i++)
			send_char(text[i], i == text.size() - 1);
	endtask

	// The block may still hold an item of an unfinished string, so the task waits and idles first.
	task automatic write_base(input logic [1:0] base);
		s_axis_tvalid <= 1'b0;
		while (results_owed != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= base;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] digit_char(input int d, input bit upper);
		if (d < 10)
			return CHR_ZERO + 8'(d);
		return (upper ? CHR_UC_A : CHR_LC_A) + 8'(d - 10);
	endfunction

	// Mostly well-formed numbers with random content, some pure noise and some broken ones.
	task automatic compose_number(input logic [1:0] base);
		int    r;
		int    n;
		int    v;
		bit    hexdigits;
		string edge_case;
		text.delete();
		r = $urandom_range(0, 99);
		if (r < 12) begin
			n = $urandom_range(1, 6);
			repeat (n) text.push_back(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 99) < 40) begin
				n = $urandom_range(1, 3);
				repeat (n) begin
					v = $urandom_range(9, 14);
					text.push_back(v == 14 ? CHR_SPACE : 8'(v));
				end
			end
			r = $urandom_range(0, 99);
			if (r < 25)
				text.push_back(CHR_PLUS);
			else if (r < 50)
				text.push_back(CHR_MINUS);
			hexdigits = (base == BASE_HEX);
			if (base != BASE_DEC && $urandom_range(0, 99) < 35) begin
				text.push_back(CHR_ZERO);
				text.push_back($urandom_range(0, 1) ? CHR_UC_X : CHR_LC_X);
				hexdigits = 1'b1;
			end
			if ($urandom_range(0, 99) < 10) begin
				r = $urandom_range(0, 2);
				if (hexdigits)
					edge_case = (r == 0) ? "7fffffff" : (r == 1) ? "80000000" : "FFFFFFFF";
				else
					edge_case = (r == 0) ? "2147483647" : (r == 1) ? "2147483648"
						: "4294967295";
				for (int i = 0; i < edge_case.len(); i++)
					text.push_back(edge_case[i]);
			end else begin
				n = $urandom_range(1, 12);
				repeat (n) begin
					if (!hexdigits && $urandom_range(0, 99) < 3)
						text.push_back(digit_char($urandom_range(10, 15),
							1'($urandom_range(0, 1))));
					else
						text.push_back(digit_char($urandom_range(0, hexdigits ? 15 : 9),
							1'($urandom_range(0, 1))));
				end
			end
			r = $urandom_range(0, 99);
			if (r < 15)
				text.push_back(8'($urandom_range(0, 255)));
			else if (r < 20)
				text.push_back($urandom_range(0, 1) ? CHR_PLUS : CHR_MINUS);
			if ($urandom_range(0, 99) < 10)
				text.insert($urandom_range(0, text.size() - 1), 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int sent;
		logic [1:0] base;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = BASE_AUTO;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		steady = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Automatic base straight after reset.
		send_char(8'h0B, 1'b0);
		send_str("-0X1f");
		send_str("0x");
		send_str("012");
		send_str("+-5");
		send_char("7", 1'b0);
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);
		write_base(BASE_HEX);
		send_str("fffffffff");
		write_base(BASE_RESERVED);
		send_str("0xA");
		// The base is settled by the first digit, so a change afterwards must not apply.
		write_base(BASE_DEC);
		send_char("1", 1'b0);
		write_base(BASE_HEX);
		send_char("f", 1'b1);

		for (int p = 0; p < 10; p++) begin
			base = 2'(p % 4);
			write_base(base);
			steady = (p % 3 == 2);
			sent = 0;
			while (sent < CHARS_PER_PHASE) begin
				compose_number(base);
				send_text();
				sent += text.size();
			end
		end

		s_axis_tvalid <= 1'b0;
		while (results_owed != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0 && results_owed == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
